### design/flba_pkg.sv
// Shared types, constants and codes for the fixed-block free-list allocator.
`default_nettype none
package flba_pkg;

	localparam int MAX_BLOCKS = 256;
	localparam int LINK_DEPTH = 256;
	localparam int POOL_MAX   = (MAX_BLOCKS < LINK_DEPTH) ? MAX_BLOCKS : LINK_DEPTH;
	localparam logic [8:0] POOL_MAX_W = 9'(POOL_MAX);

	localparam logic [1:0] MODE_GET     = 2'd0;
	localparam logic [1:0] MODE_PUT     = 2'd1;
	localparam logic [1:0] MODE_REBUILD = 2'd2;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_GET,
		S_REBUILD
	} state_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] block_index;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] granted_block;
		logic [8:0] free_blocks;
		logic [8:0] low_water;
	} out_item_t;

	typedef struct packed {
		logic    put;
		logic    get_fin;
		logic    rb_start;
		logic    rb_step;
		logic    emit;
		status_t code;
	} ctl_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic rb_done;
	} dp_stat_t;

	function automatic logic [8:0] pool_size(input logic [8:0] count);
		return (count > POOL_MAX_W) ? POOL_MAX_W : count;
	endfunction

endpackage
`default_nettype wire

### design/flba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module flba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= (we && (waddr == raddr)) ? wdata : mem_q[raddr];
	end

endmodule
`default_nettype wire

### design/flba_ctrl.sv
// Controller state machine for the free-list allocator.
`default_nettype none
module flba_ctrl import flba_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic [1:0] mode,
	input  wire dp_stat_t stat,
	output logic          busy,
	output ctl_cmd_t      cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.code = STAT_DONE;
		busy    = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (mode)
						MODE_GET: begin
							if (stat.empty) begin
								cmd.emit = 1'b1;
								cmd.code = STAT_EMPTY;
							end else begin
								state_d = S_GET;
							end
						end
						MODE_PUT: begin
							cmd.emit = 1'b1;
							if (stat.full) begin
								cmd.code = STAT_FULL;
							end else begin
								cmd.put = 1'b1;
							end
						end
						MODE_REBUILD: begin
							cmd.rb_start = 1'b1;
							state_d = S_REBUILD;
						end
						default: begin
							cmd.emit = 1'b1;
						end
					endcase
				end
			end
			S_GET: begin
				cmd.get_fin = 1'b1;
				cmd.emit    = 1'b1;
				state_d     = S_IDLE;
			end
			S_REBUILD: begin
				cmd.rb_step = 1'b1;
				if (stat.rb_done) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

### design/flba_dp.sv
// Datapath: pool registers, link memory access and result register.
`default_nettype none
module flba_dp import flba_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire ctl_cmd_t cmd,
	input  wire in_item_t item,
	input  wire logic     cfg_we,
	input  wire logic [8:0] cfg_data,
	output dp_stat_t      stat,
	output logic          done,
	output out_item_t     result
);

	logic [8:0] block_count_q;
	logic [7:0] head_q, head_d;
	logic [8:0] free_q, free_d;
	logic [8:0] cap_q, cap_d;
	logic [8:0] min_q, min_d;
	logic [8:0] n_q;
	logic [7:0] idx_q;
	logic       last;
	logic       we;
	logic [7:0] waddr, wdata, rdata;
	logic       done_q;
	out_item_t  res_q;

	flba_ram #(
		.WIDTH(8),
		.DEPTH(LINK_DEPTH)
	) u_link (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(head_q),
		.rdata(rdata)
	);

	assign last          = (({1'b0, idx_q} + 9'd1) == n_q);
	assign stat.empty    = (free_q == 9'd0);
	assign stat.full     = (free_q >= cap_q);
	assign stat.rb_done  = (n_q == 9'd0) || last;

	always_comb begin
		head_d = head_q;
		free_d = free_q;
		cap_d  = cap_q;
		min_d  = min_q;
		we     = 1'b0;
		waddr  = idx_q;
		wdata  = last ? 8'd0 : idx_q + 8'd1;
		if (cmd.put) begin
			we     = 1'b1;
			waddr  = item.block_index;
			wdata  = head_q;
			head_d = item.block_index;
			free_d = free_q + 9'd1;
		end
		if (cmd.get_fin) begin
			free_d = free_q - 9'd1;
			head_d = (free_d != 9'd0) ? rdata : 8'd0;
			if (min_q > free_d) begin
				min_d = free_d;
			end
		end
		if (cmd.rb_step) begin
			we = (n_q != 9'd0);
			if (stat.rb_done) begin
				head_d = 8'd0;
				free_d = n_q;
				cap_d  = n_q;
				min_d  = n_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= '0;
			head_q        <= '0;
			free_q        <= '0;
			cap_q         <= '0;
			min_q         <= '0;
			done_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				block_count_q <= cfg_data;
			end
			head_q <= head_d;
			free_q <= free_d;
			cap_q  <= cap_d;
			min_q  <= min_d;
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rb_start) begin
			n_q   <= pool_size(block_count_q);
			idx_q <= '0;
		end else if (cmd.rb_step) begin
			idx_q <= idx_q + 8'd1;
		end
		if (cmd.emit) begin
			res_q.status        <= cmd.code;
			res_q.granted_block <= cmd.get_fin ? head_q : 8'd0;
			res_q.free_blocks   <= free_d;
			res_q.low_water     <= min_d;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
`default_nettype wire

### design/fixed_block_free_list_allocator.sv
// Top level of the fixed-block free-list allocator.
//
// Command channel: drive item and raise start; the item is taken at an edge
// where start is high and busy is low. Modes: get pops the head block, put
// pushes item.block_index, rebuild chains blocks 0..N-1 from block_count.
// Result channel: done is high for exactly one cycle with result valid; the
// receiver must take it then, there is no back-pressure.
// Config channel: cfg_data is written to block_count when cfg_valid is high;
// cfg_ready is always high. Write only while the block is idle.
// From accept to done: put, refused get and unknown mode register done from
// the accepting cycle; get passes through S_GET for the registered read of
// the link memory; rebuild steps through S_REBUILD, one link memory write per
// block. A put may be followed by a new item in the next cycle; a get holds
// busy for one cycle and a rebuild for as long as it steps through S_REBUILD.
// Reset clears the pool to empty (zero capacity) and block_count to zero;
// the link memory holds no reset value and is filled by rebuild and put.
`default_nettype none
module fixed_block_free_list_allocator import flba_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire in_item_t   item,
	output logic            done,
	output out_item_t       result,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [8:0] cfg_data
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	flba_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.mode  (item.mode),
		.stat  (stat),
		.busy  (busy),
		.cmd   (cmd)
	);

	flba_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.item    (item),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.stat    (stat),
		.done    (done),
		.result  (result)
	);

endmodule
`default_nettype wire

### design/flba_checker.sv
// Port-level checks for the free-list allocator, bound to the top level.
`default_nettype none
module flba_checker import flba_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire in_item_t   item,
	input wire logic       done,
	input wire out_item_t  result
);

	a_put_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.mode == MODE_PUT) |=> done && !busy)
		else $error("put result not delivered in one cycle");

	a_rebuild_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.mode == MODE_REBUILD) |=> busy && !done)
		else $error("rebuild did not hold busy");

	a_low_water: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.low_water <= result.free_blocks))
		else $error("low-water mark above free count");

	a_refused_grant: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status != STAT_DONE) |-> (result.granted_block == 8'd0))
		else $error("refused item granted a block");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == STAT_EMPTY) |-> (result.free_blocks == 9'd0))
		else $error("empty refusal with free blocks");

endmodule

bind fixed_block_free_list_allocator flba_checker u_flba_checker (.*);
`default_nettype wire
